// File: hdl/ookt_pkg.sv
`timescale 1ns / 1ps

package ookt_pkg;

    localparam int OUTLET_COUNT = 5;

    localparam logic [7:0] PREAMBLE = 8'd85;
    localparam logic [3:0] NIB_ON   = 4'd3;
    localparam logic [3:0] NIB_OFF  = 4'd12;
    localparam logic [4:0] LAST_BIT = 5'd24;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_SYNC
    } t_phase;

    typedef enum logic [2:0] {
        CFG_SHORT_PULSE,
        CFG_SYNC_GAP,
        CFG_REPEAT,
        CFG_CODE_ONE,
        CFG_CODE_TWO,
        CFG_CODE_THREE,
        CFG_CODE_FOUR,
        CFG_CODE_FIVE
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]       short_pulse;
        logic [15:0]      sync_gap;
        logic [3:0]       repeat_count;
        logic [4:0][11:0] codes;
    } t_cfg;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic refused;
    } t_result;

endpackage

// File: hdl/ookt_engine.sv
`timescale 1ns / 1ps

module ookt_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_action,
    input  logic [2:0]      i_target,
    input  logic            i_turn_on,
    input  ookt_pkg::t_cfg  i_cfg,
    output ookt_pkg::t_result o_result
);
    import ookt_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [24:0] r_frame_bits,   n_frame_bits;
    logic [4:0]  r_bit_position, n_bit_position;
    logic [15:0] r_tick_count,   n_tick_count;
    logic [3:0]  r_repeats_left, n_repeats_left;
    logic [2:0]  r_outlet_index, n_outlet_index;
    logic [2:0]  r_saved_target, n_saved_target;
    logic        r_saved_on,     n_saved_on;
    logic        r_active,       n_active;

    logic [9:0]  pulse;
    logic [11:0] pulse3;
    logic [3:0]  reps;
    logic [4:0]  bit_sel;
    logic        cur_bit;
    logic [16:0] tick_next;
    logic [16:0] len_high;
    logic [16:0] len_low;
    logic        do_end;
    logic        do_load;
    logic [2:0]  load_idx;
    logic        load_on;
    logic [3:0]  rep_dec;
    logic        start_ok;

    function automatic logic [11:0] code_of(input t_cfg cfg, input logic [2:0] idx);
        logic [11:0] c;
        unique case (idx)
            3'd0:    c = cfg.codes[0];
            3'd1:    c = cfg.codes[1];
            3'd2:    c = cfg.codes[2];
            3'd3:    c = cfg.codes[3];
            3'd4:    c = cfg.codes[4];
            3'd5:    c = cfg.codes[0];
            3'd6:    c = cfg.codes[1];
            default: c = cfg.codes[2];
        endcase
        return c;
    endfunction

    always_comb begin
        pulse     = (i_cfg.short_pulse == 10'd0) ? 10'd1 : i_cfg.short_pulse;
        pulse3    = ({2'b00, pulse} << 1) + {2'b00, pulse};
        reps      = (i_cfg.repeat_count == 4'd0) ? 4'd1 : i_cfg.repeat_count;
        bit_sel   = LAST_BIT - ((r_bit_position > LAST_BIT) ? LAST_BIT : r_bit_position);
        cur_bit   = r_frame_bits[bit_sel];
        tick_next = {1'b0, r_tick_count} + 17'd1;
        len_high  = cur_bit ? {5'd0, pulse3} : {7'd0, pulse};
        len_low   = cur_bit ? {7'd0, pulse} : {5'd0, pulse3};
        start_ok  = !r_active && ({1'b0, i_target} <= 4'(OUTLET_COUNT));

        n_phase        = r_phase;
        n_frame_bits   = r_frame_bits;
        n_bit_position = r_bit_position;
        n_tick_count   = r_tick_count;
        n_repeats_left = r_repeats_left;
        n_outlet_index = r_outlet_index;
        n_saved_target = r_saved_target;
        n_saved_on     = r_saved_on;
        n_active       = r_active;

        do_end   = 1'b0;
        do_load  = 1'b0;
        load_idx = r_outlet_index + 3'd1;
        load_on  = r_saved_on;
        rep_dec  = r_repeats_left - {3'd0, (r_repeats_left != 4'd0)};

        o_result.pin_level = r_active && (r_phase == PH_HIGH);
        o_result.refused   = 1'b0;
        o_result.busy_res  = r_active;

        if (i_accept && i_action) begin
            // start command: no tick consumed
            if (start_ok) begin
                n_saved_target = i_target;
                n_saved_on     = i_turn_on;
                n_active       = 1'b1;
                do_load        = 1'b1;
                load_on        = i_turn_on;
                load_idx       = (i_target == 3'd0) ? 3'd0 : i_target - 3'd1;
                o_result.busy_res = 1'b1;
            end else begin
                o_result.refused = 1'b1;
            end
        end else if (i_accept && r_active) begin
            unique case (r_phase)
                PH_HIGH: begin
                    if (tick_next >= len_high) begin
                        n_phase      = PH_LOW;
                        n_tick_count = 16'd0;
                    end else begin
                        n_tick_count = tick_next[15:0];
                    end
                end
                PH_LOW: begin
                    if (tick_next >= len_low) begin
                        n_tick_count = 16'd0;
                        if (r_bit_position < LAST_BIT) begin
                            n_bit_position = r_bit_position + 5'd1;
                            n_phase        = PH_HIGH;
                        end else if (i_cfg.sync_gap == 16'd0) begin
                            do_end = 1'b1;
                        end else begin
                            n_phase = PH_SYNC;
                        end
                    end else begin
                        n_tick_count = tick_next[15:0];
                    end
                end
                PH_SYNC: begin
                    if (tick_next >= {1'b0, i_cfg.sync_gap}) begin
                        do_end = 1'b1;
                    end else begin
                        n_tick_count = tick_next[15:0];
                    end
                end
                default: ;
            endcase
        end

        if (do_end) begin
            n_repeats_left = rep_dec;
            if (rep_dec != 4'd0) begin
                n_bit_position = 5'd0;
                n_phase        = PH_HIGH;
                n_tick_count   = 16'd0;
            end else if (r_saved_target == 3'd0 &&
                         ({1'b0, r_outlet_index} + 4'd1) < 4'(OUTLET_COUNT)) begin
                do_load = 1'b1;
            end else begin
                n_phase        = PH_IDLE;
                n_active       = 1'b0;
                n_tick_count   = 16'd0;
                n_bit_position = 5'd0;
            end
        end

        if (do_load) begin
            n_outlet_index = load_idx;
            n_frame_bits   = {PREAMBLE, code_of(i_cfg, load_idx),
                              load_on ? NIB_ON : NIB_OFF, 1'b0};
            n_repeats_left = reps;
            n_bit_position = 5'd0;
            n_phase        = PH_HIGH;
            n_tick_count   = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_frame_bits   <= '0;
            r_bit_position <= '0;
            r_tick_count   <= '0;
            r_repeats_left <= '0;
            r_outlet_index <= '0;
            r_saved_target <= '0;
            r_saved_on     <= 1'b0;
            r_active       <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_frame_bits   <= n_frame_bits;
            r_bit_position <= n_bit_position;
            r_tick_count   <= n_tick_count;
            r_repeats_left <= n_repeats_left;
            r_outlet_index <= n_outlet_index;
            r_saved_target <= n_saved_target;
            r_saved_on     <= n_saved_on;
            r_active       <= n_active;
        end
    end

endmodule

// File: hdl/ook_remote_frame_transmitter.sv
`timescale 1ns / 1ps
// Channel  | Handshake                | Payload
// ---------+--------------------------+----------------------------------
// input    | i_in_valid / o_in_ready  | i_action, i_target, i_turn_on
// result   | o_out_valid / i_out_ready| o_pin_level, o_busy_res, o_refused
// config   | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
// One beat per cycle while the result is not stalled: each accepted beat
// updates the frame state and loads the result register in the same cycle.
// The result register is the only limit: input is taken whenever it is
// empty or being drained, so a stalled result stalls input.
// Synchronous active-low reset clears the frame state, the result valid
// and restores the register defaults.

module ook_remote_frame_transmitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [2:0]  i_target,
    input  logic        i_turn_on,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_pin_level,
    output logic        o_busy_res,
    output logic        o_refused,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import ookt_pkg::*;

    t_cfg    r_cfg;
    t_result eng_result;
    t_result r_result;
    logic    r_out_valid;
    logic    accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_pulse  <= 10'd184;
            r_cfg.sync_gap     <= 16'd5000;
            r_cfg.repeat_count <= 4'd6;
            r_cfg.codes[0]     <= 12'd339;
            r_cfg.codes[1]     <= 12'd348;
            r_cfg.codes[2]     <= 12'd368;
            r_cfg.codes[3]     <= 12'd464;
            r_cfg.codes[4]     <= 12'd848;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_PULSE: r_cfg.short_pulse  <= i_cfg_wdata[9:0];
                CFG_SYNC_GAP:    r_cfg.sync_gap     <= i_cfg_wdata;
                CFG_REPEAT:      r_cfg.repeat_count <= i_cfg_wdata[3:0];
                CFG_CODE_ONE:    r_cfg.codes[0]     <= i_cfg_wdata[11:0];
                CFG_CODE_TWO:    r_cfg.codes[1]     <= i_cfg_wdata[11:0];
                CFG_CODE_THREE:  r_cfg.codes[2]     <= i_cfg_wdata[11:0];
                CFG_CODE_FOUR:   r_cfg.codes[3]     <= i_cfg_wdata[11:0];
                CFG_CODE_FIVE:   r_cfg.codes[4]     <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    ookt_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_action  (i_action),
        .i_target  (i_target),
        .i_turn_on (i_turn_on),
        .i_cfg     (r_cfg),
        .o_result  (eng_result)
    );

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= eng_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_result.pin_level;
    assign o_busy_res  = r_result.busy_res;
    assign o_refused   = r_result.refused;

endmodule

// File: hdl/ookt_checker.sv
`timescale 1ns / 1ps

module ookt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_action,
    input logic [2:0] i_target,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_pin_level,
    input logic       o_busy_res,
    input logic       o_refused
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
        $stable({o_pin_level, o_busy_res, o_refused}))
        else $error("result beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_pin_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pin_level |-> o_busy_res)
        else $error("pin high outside a transmission");

    a_bad_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action && (i_target == 3'd6 || i_target == 3'd7)
        |=> o_out_valid && o_refused)
        else $error("out-of-range target not refused");

    a_tick_not_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_action |=> o_out_valid && !o_refused)
        else $error("tick beat flagged as refused");

endmodule

bind ook_remote_frame_transmitter ookt_checker u_ookt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .i_target    (i_target),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pin_level (o_pin_level),
    .o_busy_res  (o_busy_res),
    .o_refused   (o_refused)
);
